// ===== src/trsf_pkg.sv =====
`default_nettype none

package trsf_pkg;

  localparam int ByteW      = 8;
  localparam int ValueW     = 16;
  localparam int FrameBytes = 6;
  localparam int CountW     = $clog2(FrameBytes + 1);
  localparam int IdxW       = $clog2(FrameBytes);
  localparam int CfgIdxW    = 1;

  localparam logic [ByteW-1:0] EscFlag  = 8'h5e;
  localparam logic [ByteW-1:0] EscMark  = 8'h5d;
  localparam logic [ByteW-1:0] EscFlagX = 8'h3e;
  localparam logic [ByteW-1:0] EscMarkX = 8'h3d;
  localparam logic [ByteW-1:0] CfgReset = EscFlag;

  localparam logic OpData = 1'b0;
  localparam logic OpTail = 1'b1;

  localparam logic [CfgIdxW-1:0] RegHeader = 1'd0;
  localparam logic [CfgIdxW-1:0] RegTail   = 1'd1;

  typedef struct packed {
    logic [ByteW-1:0] header;
    logic [ByteW-1:0] tail;
  } cfg_regs_t;

  typedef struct packed {
    logic [FrameBytes-1:0][ByteW-1:0] bytes;
    logic [CountW-1:0]                count;
  } frame_t;

  // Returns {escaped, byte}: the byte that follows the escape mark, or the
  // byte itself when no escape is needed.
  function automatic logic [ByteW:0] stuff_byte(input logic [ByteW-1:0] b);
    logic [ByteW:0] r;
    if (b == EscFlag) begin
      r = {1'b1, EscFlagX};
    end else if (b == EscMark) begin
      r = {1'b1, EscMarkX};
    end else begin
      r = {1'b0, b};
    end
    return r;
  endfunction

  function automatic frame_t build_frame(input logic             opcode,
                                         input logic [ByteW-1:0]  id,
                                         input logic [ValueW-1:0] value,
                                         input cfg_regs_t         cfg);
    frame_t           f;
    logic [ByteW:0]   lo_s;
    logic [ByteW:0]   hi_s;
    logic             lo_esc;
    logic             hi_esc;
    logic [ByteW-1:0] hi_first;
    f        = '0;
    lo_s     = stuff_byte(value[ByteW-1:0]);
    hi_s     = stuff_byte(value[ValueW-1:ByteW]);
    lo_esc   = lo_s[ByteW];
    hi_esc   = hi_s[ByteW];
    hi_first = hi_esc ? EscMark : hi_s[ByteW-1:0];
    if (opcode == OpTail) begin
      f.bytes[0] = cfg.tail;
      f.count    = CountW'(1);
    end else begin
      f.bytes[0] = cfg.header;
      f.bytes[1] = id;
      f.bytes[2] = lo_esc ? EscMark : lo_s[ByteW-1:0];
      f.bytes[3] = lo_esc ? lo_s[ByteW-1:0] : hi_first;
      f.bytes[4] = lo_esc ? hi_first : hi_s[ByteW-1:0];
      f.bytes[5] = hi_s[ByteW-1:0];
      f.count    = CountW'(4) + CountW'(lo_esc) + CountW'(hi_esc);
    end
    return f;
  endfunction

endpackage

`default_nettype wire

// ===== src/trsf_if.sv =====
`default_nettype none

interface trsf_rec_if;
  logic                            valid;
  logic                            ready;
  logic                            opcode;
  logic [trsf_pkg::ByteW-1:0]      record_id;
  logic [trsf_pkg::ValueW-1:0]     record_value;

  modport source (output valid, opcode, record_id, record_value, input ready);
  modport sink   (input valid, opcode, record_id, record_value, output ready);
endinterface

interface trsf_byte_if;
  logic                       valid;
  logic                       ready;
  logic [trsf_pkg::ByteW-1:0] out_byte;
  logic                       last_byte;

  modport source (output valid, out_byte, last_byte, input ready);
  modport sink   (input valid, out_byte, last_byte, output ready);
endinterface

interface trsf_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [trsf_pkg::CfgIdxW-1:0] index;
  logic [trsf_pkg::ByteW-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== src/trsf_cfg.sv =====
`default_nettype none

module trsf_cfg (
  input  wire logic          clk,
  input  wire logic          rst,
  trsf_cfg_if.sink           cfg,
  output trsf_pkg::cfg_regs_t regs
);

  trsf_pkg::cfg_regs_t regs_next;

  assign cfg.ready = 1'b1;

  always_comb begin
    regs_next = regs;
    if (cfg.valid) begin
      case (cfg.index)
        trsf_pkg::RegHeader: regs_next.header = cfg.data;
        trsf_pkg::RegTail:   regs_next.tail   = cfg.data;
        default:             regs_next        = regs;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.header <= trsf_pkg::CfgReset;
      regs.tail   <= trsf_pkg::CfgReset;
    end else begin
      regs <= regs_next;
    end
  end

endmodule

`default_nettype wire

// ===== src/trsf_expand.sv =====
`default_nettype none

module trsf_expand (
  input  wire logic                 clk,
  input  wire logic                 rst,
  trsf_rec_if.sink                  rec_in,
  input  wire trsf_pkg::cfg_regs_t  regs,
  output trsf_pkg::frame_t          frame,
  output logic                      frame_valid,
  input  wire logic                 frame_take
);

  logic accept;

  assign rec_in.ready = !frame_valid || frame_take;
  assign accept       = rec_in.valid && rec_in.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_valid <= 1'b0;
    end else if (accept) begin
      frame_valid <= 1'b1;
    end else if (frame_take) begin
      frame_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      frame <= trsf_pkg::build_frame(rec_in.opcode, rec_in.record_id,
                                     rec_in.record_value, regs);
    end
  end

  // A held frame is either a single tail byte or a record of four to six bytes.
  assert property (@(posedge clk) disable iff (rst)
    frame_valid |-> (frame.count == trsf_pkg::CountW'(1) ||
                     frame.count == trsf_pkg::CountW'(4) ||
                     frame.count == trsf_pkg::CountW'(5) ||
                     frame.count == trsf_pkg::CountW'(6)))
    else $error("held frame has an impossible byte count");

endmodule

`default_nettype wire

// ===== src/trsf_emit.sv =====
`default_nettype none

module trsf_emit (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire trsf_pkg::frame_t  frame,
  input  wire logic              frame_valid,
  output logic                   frame_take,
  trsf_byte_if.source            byte_out
);

  logic [trsf_pkg::IdxW-1:0] idx;
  logic                      out_free;
  logic                      emit;
  logic                      is_last;

  assign out_free   = !byte_out.valid || byte_out.ready;
  assign emit       = frame_valid && out_free;
  assign is_last    = trsf_pkg::CountW'(idx) == frame.count - trsf_pkg::CountW'(1);
  assign frame_take = emit && is_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx            <= '0;
      byte_out.valid <= 1'b0;
    end else begin
      if (emit) begin
        idx            <= is_last ? '0 : idx + trsf_pkg::IdxW'(1);
        byte_out.valid <= 1'b1;
      end else if (byte_out.ready) begin
        byte_out.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      byte_out.out_byte  <= frame.bytes[idx];
      byte_out.last_byte <= is_last;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    frame_valid |-> trsf_pkg::CountW'(idx) < frame.count)
    else $error("byte index ran past the end of the frame");

  assert property (@(posedge clk) disable iff (rst)
    frame_take |=> idx == '0)
    else $error("byte index not rewound after the last byte");

  assert property (@(posedge clk) disable iff (rst)
    idx != '0 |-> frame_valid)
    else $error("byte index moved with no frame held");

endmodule

`default_nettype wire

// ===== src/telemetry_record_stuffing_framer.sv =====
// Record framer with byte stuffing for a serial telemetry line.
// rec_in carries one transaction per item: opcode 0 is a data record
// (record_id, record_value), opcode 1 is a frame tail. byte_out gives one
// byte per transaction: a record yields the header byte, the id byte, and
// the low then high value bytes, each value byte stuffed (0x5e and 0x5d are
// sent as 0x5d followed by 0x3e or 0x3d); a tail yields the tail byte.
// last_byte is set on the final byte of each item.
// cfg writes register 0 (header byte) or 1 (tail byte); it is always ready
// and should be written only while the block is idle.
// The first byte of an item passes through the frame register and then the
// output register after its transaction on rec_in. An item has one byte
// for a tail and four to six for a record; a new item is taken in the
// cycle its predecessor's last byte moves to the output register.
// On a byte_out stall the output register holds its byte, the frame register
// the rest; rec_in.ready is low while a frame is held and not being taken.
// Reset (rst, synchronous) empties both registers and sets both
// configuration bytes to 0x5e.
`default_nettype none

module telemetry_record_stuffing_framer (
  input  wire logic   clk,
  input  wire logic   rst,
  trsf_rec_if.sink    rec_in,
  trsf_byte_if.source byte_out,
  trsf_cfg_if.sink    cfg
);

  trsf_pkg::cfg_regs_t regs;
  trsf_pkg::frame_t    frame;
  logic                frame_valid;
  logic                frame_take;

  trsf_cfg u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  trsf_expand u_expand (
    .clk         (clk),
    .rst         (rst),
    .rec_in      (rec_in),
    .regs        (regs),
    .frame       (frame),
    .frame_valid (frame_valid),
    .frame_take  (frame_take)
  );

  trsf_emit u_emit (
    .clk         (clk),
    .rst         (rst),
    .frame       (frame),
    .frame_valid (frame_valid),
    .frame_take  (frame_take),
    .byte_out    (byte_out)
  );

endmodule

`default_nettype wire
